>>> hdl/piq_pkg.sv
// Shared types and codes for the positional insert queue.
package piq_pkg;

   typedef struct packed {
      logic [15:0] name_tag;
      logic [7:0]  priority_req;
      logic [15:0] city_tag;
      logic [15:0] aid_needed;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

>>> hdl/piq_cell.sv
// One queue cell: holds one record and shifts toward its neighbors.
module piq_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 9
) (
   input  logic                   clock,
   input  piq_pkg::cell_ctrl_type ctrl,
   input  logic [POS_W-1:0]       ins_pos,
   input  piq_pkg::rec_type       new_rec,
   input  piq_pkg::rec_type       left_rec,
   input  piq_pkg::rec_type       right_rec,
   output piq_pkg::rec_type       rec_out
);
   import piq_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   rec_type rec_ff;
   rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.insert) begin
         if (MY_POS == ins_pos) begin
            rec_in = new_rec;
         end else if (MY_POS > ins_pos) begin
            rec_in = left_rec;
         end
      end else if (ctrl.pop) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

>>> hdl/positional_insert_queue.sv
// Top level of the positional insert queue: a row of record cells and a fill counter.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | action, name, priority, city, aid
//   rsp     | out       | rsp_valid / rsp_ready  | status, popped record, occupancy
//
// One request per cycle when not stalled by rsp_ready: every cell compares its index
// with the insert position and shifts in the same cycle, and the result lands in the
// output register. The response appears in the cycle after acceptance.
// Reset clears the fill count and the output valid; cell contents are not reset.
// A stalled response holds; a new request is taken in the cycle it is taken out.
module positional_insert_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_name_tag,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_city_tag,
   input  logic [15:0] req_aid_needed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_name_tag,
   output logic [7:0]  rsp_out_priority,
   output logic [15:0] rsp_out_city_tag,
   output logic [15:0] rsp_out_aid_needed,
   output logic [4:0]  rsp_occupancy
);
   import piq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   rec_type          out_rec_ff, out_rec_in;
   logic [4:0]       occ_ff, occ_in;

   rec_type          cell_q [QUEUE_DEPTH];
   rec_type          new_rec;
   cell_ctrl_type    ctrl;
   logic             accept;
   logic             is_full, is_empty;
   logic [POS_W-1:0] want_pos, limit_pos, ins_pos;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);

   assign new_rec.name_tag     = req_name_tag;
   assign new_rec.priority_req = req_priority_req;
   assign new_rec.city_tag     = req_city_tag;
   assign new_rec.aid_needed   = req_aid_needed;

   always_comb begin
      want_pos  = (req_priority_req == 8'd0) ? POS_W'(2) : POS_W'(req_priority_req);
      limit_pos = POS_W'(count_ff) + POS_W'(1);
      ins_pos   = ((want_pos > limit_pos) ? limit_pos : want_pos) - POS_W'(1);
   end

   always_comb begin
      ctrl.insert  = accept && (req_action == ACT_INSERT) && !is_full;
      ctrl.pop     = accept && (req_action == ACT_POP) && !is_empty;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_rec_in   = out_rec_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_rec_in   = '0;
         occ_in       = 5'(count_in);
         if (req_action == ACT_INSERT) begin
            status_in = is_full ? STATUS_FULL : STATUS_DONE;
         end else if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in  = STATUS_DONE;
            out_rec_in = cell_q[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_rec_ff <= out_rec_in;
      occ_ff     <= occ_in;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      rec_type left_rec, right_rec;
      if (i == 0) begin : g_first
         assign left_rec = new_rec;
      end else begin : g_mid_left
         assign left_rec = cell_q[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_rec = cell_q[i];
      end else begin : g_mid_right
         assign right_rec = cell_q[i+1];
      end
      piq_cell #(
         .INDEX (i),
         .POS_W (POS_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .ins_pos   (ins_pos),
         .new_rec   (new_rec),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .rec_out   (cell_q[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_name_tag   = out_rec_ff.name_tag;
   assign rsp_out_priority   = out_rec_ff.priority_req;
   assign rsp_out_city_tag   = out_rec_ff.city_tag;
   assign rsp_out_aid_needed = out_rec_ff.aid_needed;
   assign rsp_occupancy      = occ_ff;

endmodule

>>> hdl/piq_checker.sv
// Port-level checks for the positional insert queue, bound to the top level.
module piq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_out_name_tag,
   input logic [7:0]  rsp_out_priority,
   input logic [15:0] rsp_out_city_tag,
   input logic [15:0] rsp_out_aid_needed,
   input logic [4:0]  rsp_occupancy
);
   import piq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_name_tag) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_out_name_tag == '0
         && rsp_out_priority == '0 && rsp_out_city_tag == '0 && rsp_out_aid_needed == '0)
      else $error("record fields set on a failed request");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_occupancy == '0)
      else $error("empty pop reports nonzero occupancy");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with free output");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind positional_insert_queue piq_checker u_piq_checker (.*);
